[sv/hcs_pkg.sv]
`default_nettype none

package hcs_pkg;

   // fixed field widths
   localparam int SIZE_W      = 11;
   localparam int COORD_W     = 10;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 24;
   localparam int CSR_IDX_W   = 1;
   localparam int PHASE_W     = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

   // a bottom frame makes three moves, an inner frame interleaves four sub-walks with three moves
   localparam logic [PHASE_W-1:0] LEAF_LAST_PHASE = 3'd3;
   localparam logic [PHASE_W-1:0] NODE_LAST_PHASE = 3'd7;

   typedef logic [1:0] heading_type;

   localparam heading_type HD_UP    = 2'd0;
   localparam heading_type HD_LEFT  = 2'd1;
   localparam heading_type HD_DOWN  = 2'd2;
   localparam heading_type HD_RIGHT = 2'd3;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      heading_type        heading;
   } frame_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_LATCH,
      OP_INIT,
      OP_STEP,
      OP_SET_FIN,
      OP_HOLD,
      OP_SEND,
      OP_SEND_DONE
   } op_type;

   typedef struct packed {
      logic req_fire;
      logic restart;
      logic finished;
      logic searching;
      logic out_busy;
   } status_type;

   // move taken at the k-th move of a frame with heading h
   function automatic heading_type step_of(heading_type h, logic [1:0] k);
      heading_type d;
      unique case (k)
         2'd0:    d = h ^ 2'd2;
         2'd1:    d = ~h;
         default: d = h;
      endcase
      return d;
   endfunction

   // heading of the sub-walk entered at quarter k of a frame with heading h
   function automatic heading_type sub_of(heading_type h, logic [1:0] k);
      heading_type s;
      unique case (k)
         2'd0:    s = h ^ 2'd1;
         2'd3:    s = ~h;
         default: s = h;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

[sv/hcs_sequencer.sv]
`default_nettype none

module hcs_sequencer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire hcs_pkg::status_type status,
   output hcs_pkg::op_type          op
);
   import hcs_pkg::*;

   typedef enum logic [2:0] {
      C_ALWAYS,
      C_NO_REQ,
      C_NO_RESTART,
      C_FINISHED,
      C_SEARCHING,
      C_OUT_BUSY
   } cond_type;

   typedef logic [3:0] pc_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   jump;
      pc_type   next;
   } uword_type;

   localparam pc_type PC_WAIT      = 4'd0;
   localparam pc_type PC_BRANCH    = 4'd1;
   localparam pc_type PC_LATCH     = 4'd2;
   localparam pc_type PC_INIT      = 4'd3;
   localparam pc_type PC_FETCH_A   = 4'd4;
   localparam pc_type PC_SET_FIN   = 4'd5;
   localparam pc_type PC_CHECK     = 4'd6;
   localparam pc_type PC_HOLD      = 4'd7;
   localparam pc_type PC_FETCH_B   = 4'd8;
   localparam pc_type PC_SEND      = 4'd9;
   localparam pc_type PC_SEND_DONE = 4'd10;

   // control store: taken jump when the condition holds, else fall to next
   function automatic uword_type ucode(pc_type pc);
      uword_type w;
      unique case (pc)
         PC_WAIT:      w = '{OP_ACCEPT,    C_NO_REQ,     PC_WAIT,      PC_BRANCH};
         PC_BRANCH:    w = '{OP_NONE,      C_NO_RESTART, PC_CHECK,     PC_LATCH};
         PC_LATCH:     w = '{OP_LATCH,     C_ALWAYS,     PC_INIT,      PC_INIT};
         PC_INIT:      w = '{OP_INIT,      C_ALWAYS,     PC_FETCH_A,   PC_FETCH_A};
         PC_FETCH_A:   w = '{OP_STEP,      C_SEARCHING,  PC_FETCH_A,   PC_SET_FIN};
         PC_SET_FIN:   w = '{OP_SET_FIN,   C_ALWAYS,     PC_CHECK,     PC_CHECK};
         PC_CHECK:     w = '{OP_NONE,      C_FINISHED,   PC_SEND_DONE, PC_HOLD};
         PC_HOLD:      w = '{OP_HOLD,      C_ALWAYS,     PC_FETCH_B,   PC_FETCH_B};
         PC_FETCH_B:   w = '{OP_STEP,      C_SEARCHING,  PC_FETCH_B,   PC_SEND};
         PC_SEND:      w = '{OP_SEND,      C_OUT_BUSY,   PC_SEND,      PC_WAIT};
         PC_SEND_DONE: w = '{OP_SEND_DONE, C_OUT_BUSY,   PC_SEND_DONE, PC_WAIT};
         default:      w = '{OP_NONE,      C_ALWAYS,     PC_WAIT,      PC_WAIT};
      endcase
      return w;
   endfunction

   pc_type    pc_ff;
   pc_type    pc_in;
   uword_type word;
   logic      take;

   assign word = ucode(pc_ff);
   assign op   = word.op;

   always_comb begin
      unique case (word.cond)
         C_ALWAYS:     take = 1'b1;
         C_NO_REQ:     take = !status.req_fire;
         C_NO_RESTART: take = !status.restart;
         C_FINISHED:   take = status.finished;
         C_SEARCHING:  take = status.searching;
         C_OUT_BUSY:   take = status.out_busy;
         default:      take = 1'b0;
      endcase
      pc_in = take ? word.jump : word.next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   a_fire_branches: assert property (@(posedge clock) disable iff (reset)
      status.req_fire |=> pc_ff == PC_BRANCH)
      else $error("request taken but sequencer did not move to branch step");

   a_done_only_finished: assert property (@(posedge clock) disable iff (reset)
      pc_ff == PC_SEND_DONE |-> status.finished)
      else $error("done response issued while a scan is active");

   a_pc_in_store: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= PC_SEND_DONE)
      else $error("step counter outside the control store");

endmodule

`default_nettype wire

[sv/hcs_datapath.sv]
`default_nettype none

module hcs_datapath #(
   parameter int MAX_ORDER = 10
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire hcs_pkg::op_type                    op,
   output hcs_pkg::status_type                     status,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [hcs_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [hcs_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   output logic                                    rsp_tlast,
   output logic                                    rsp_tuser,
   input  wire logic                               csr_we,
   input  wire logic [hcs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [hcs_pkg::SIZE_W-1:0]         csr_wdata
);
   import hcs_pkg::*;

   localparam int CW   = MAX_ORDER;
   localparam int CMPW = (CW > SIZE_W) ? CW : SIZE_W;
   localparam int LW   = $clog2(MAX_ORDER + 1);
   localparam int IW   = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int BLW  = $clog2(SIZE_W + 1);

   // configuration and latched sizes
   logic [SIZE_W-1:0] width_ff, height_ff;
   logic [SIZE_W-1:0] lat_w_ff, lat_h_ff;

   // walk state
   logic [LW-1:0]     order_ff;
   logic [LW-1:0]     level_ff;
   frame_type         stack_ff [MAX_ORDER];
   logic [CW-1:0]     walk_x_ff, walk_y_ff;
   logic              walk_end_ff;
   logic [CW-1:0]     cur_x_ff, cur_y_ff;
   logic [CW-1:0]     hold_x_ff, hold_y_ff;
   logic              found_ff;
   logic              finished_ff;
   logic              restart_ff;

   // result register
   logic              rsp_valid_ff;
   logic [COORD_W-1:0] rsp_x_ff, rsp_y_ff;
   logic              rsp_last_ff;
   logic              rsp_done_ff;

   logic [SIZE_W-1:0] size;
   logic [SIZE_W-1:0] size_m1;
   logic [BLW-1:0]    blen;
   logic [LW-1:0]     order_in;

   logic [LW-1:0]     top_lvl;
   logic [IW-1:0]     top_idx;
   logic [IW-1:0]     push_idx;
   frame_type         frame_top;
   logic              leaf, empty;
   logic              visit, none_step, pop, push, advance, hit;
   heading_type       dir;
   heading_type       sub_h;
   logic [CW-1:0]     walk_x_in, walk_y_in;
   logic [CMPW-1:0]   hold_x_ext, hold_y_ext;
   logic              req_fire, out_busy, send_ok;

   // order = bit length of (size - 1), saturated
   always_comb begin
      size    = (lat_w_ff > lat_h_ff) ? lat_w_ff : lat_h_ff;
      size_m1 = size - SIZE_W'(1);
      blen    = '0;
      for (int i = 0; i < SIZE_W; i++) begin
         if (size_m1[i]) begin
            blen = BLW'(i + 1);
         end
      end
      if (size <= SIZE_W'(1)) begin
         blen = '0;
      end
      order_in = (int'(blen) > MAX_ORDER) ? LW'(MAX_ORDER) : LW'(blen);
   end

   assign top_lvl   = level_ff - LW'(1);
   assign top_idx   = top_lvl[IW-1:0];
   assign push_idx  = level_ff[IW-1:0];
   assign frame_top = stack_ff[top_idx];

   // one frame action per cycle
   always_comb begin
      leaf      = (level_ff >= order_ff);
      empty     = (level_ff == '0);
      visit     = 1'b0;
      none_step = 1'b0;
      pop       = 1'b0;
      push      = 1'b0;
      advance   = 1'b0;
      dir       = HD_UP;
      sub_h     = sub_of(frame_top.heading, frame_top.phase[2:1]);
      if (!walk_end_ff) begin
         if (empty) begin
            visit     = 1'b1;
            none_step = 1'b1;
         end else if (leaf) begin
            if (frame_top.phase >= LEAF_LAST_PHASE) begin
               pop = 1'b1;
            end else begin
               advance = 1'b1;
               visit   = 1'b1;
               dir     = step_of(frame_top.heading, frame_top.phase[1:0]);
            end
         end else begin
            if (frame_top.phase == NODE_LAST_PHASE) begin
               pop = 1'b1;
            end else begin
               advance = 1'b1;
               if (!frame_top.phase[0]) begin
                  push = 1'b1;
               end else begin
                  visit = 1'b1;
                  dir   = step_of(frame_top.heading, frame_top.phase[2:1]);
               end
            end
         end
      end
      hit = visit && (CMPW'(walk_x_ff) < CMPW'(lat_w_ff))
                  && (CMPW'(walk_y_ff) < CMPW'(lat_h_ff));
      walk_x_in = walk_x_ff;
      walk_y_in = walk_y_ff;
      unique case (dir)
         HD_LEFT:  walk_x_in = walk_x_ff - CW'(1);
         HD_RIGHT: walk_x_in = walk_x_ff + CW'(1);
         HD_UP:    walk_y_in = walk_y_ff - CW'(1);
         default:  walk_y_in = walk_y_ff + CW'(1);
      endcase
   end

   assign req_tready = (op == OP_ACCEPT);
   assign req_fire   = req_tvalid && req_tready;
   assign out_busy   = rsp_valid_ff && !rsp_tready;
   assign send_ok    = ((op == OP_SEND) || (op == OP_SEND_DONE)) && !out_busy;

   assign status = '{
      req_fire:  req_fire,
      restart:   restart_ff,
      finished:  finished_ff,
      searching: !walk_end_ff && !hit && !none_step,
      out_busy:  out_busy
   };

   assign hold_x_ext = CMPW'(hold_x_ff);
   assign hold_y_ext = CMPW'(hold_y_ff);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= SIZE_RESET;
         height_ff    <= SIZE_RESET;
         order_ff     <= '0;
         level_ff     <= '0;
         walk_end_ff  <= 1'b0;
         finished_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
               CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
               default:          width_ff  <= width_ff;
            endcase
         end
         if (send_ok) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (op)
            OP_INIT: begin
               order_ff    <= order_in;
               level_ff    <= (order_in != '0) ? LW'(1) : '0;
               walk_end_ff <= 1'b0;
            end
            OP_STEP: begin
               if (push) begin
                  level_ff <= level_ff + LW'(1);
               end else if (pop) begin
                  level_ff <= level_ff - LW'(1);
               end
               if (none_step) begin
                  walk_end_ff <= 1'b1;
               end
            end
            OP_SET_FIN: finished_ff <= !found_ff;
            OP_SEND: begin
               if (!out_busy) begin
                  finished_ff <= !found_ff;
               end
            end
            default: finished_ff <= finished_ff;
         endcase
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         restart_ff <= req_tdata[0];
      end
      unique case (op)
         OP_LATCH: begin
            lat_w_ff <= width_ff;
            lat_h_ff <= height_ff;
         end
         OP_INIT: begin
            walk_x_ff             <= '0;
            walk_y_ff             <= '0;
            stack_ff[IW'(0)]      <= '{phase: '0, heading: HD_UP};
         end
         OP_STEP: begin
            if (advance) begin
               stack_ff[top_idx].phase <= frame_top.phase + PHASE_W'(1);
            end
            if (push) begin
               stack_ff[push_idx] <= '{phase: '0, heading: sub_h};
            end
            if (visit && !none_step) begin
               walk_x_ff <= walk_x_in;
               walk_y_ff <= walk_y_in;
            end
            if (hit) begin
               cur_x_ff <= walk_x_ff;
               cur_y_ff <= walk_y_ff;
            end
            found_ff <= hit;
         end
         OP_HOLD: begin
            hold_x_ff <= cur_x_ff;
            hold_y_ff <= cur_y_ff;
         end
         OP_SEND: begin
            if (!out_busy) begin
               rsp_x_ff    <= hold_x_ext[COORD_W-1:0];
               rsp_y_ff    <= hold_y_ext[COORD_W-1:0];
               rsp_last_ff <= !found_ff;
               rsp_done_ff <= 1'b0;
            end
         end
         OP_SEND_DONE: begin
            if (!out_busy) begin
               rsp_x_ff    <= '0;
               rsp_y_ff    <= '0;
               rsp_last_ff <= 1'b0;
               rsp_done_ff <= 1'b1;
            end
         end
         default: found_ff <= found_ff;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - 2 * COORD_W)'(0), rsp_y_ff, rsp_x_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_done_ff;

   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff |-> rsp_x_ff == '0 && rsp_y_ff == '0 && !rsp_last_ff)
      else $error("done response carries a pixel");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= order_ff)
      else $error("frame stack deeper than the curve order");

   a_end_empty: assert property (@(posedge clock) disable iff (reset)
      walk_end_ff |-> level_ff == '0)
      else $error("walk ended with live frames");

endmodule

`default_nettype wire

[sv/hilbert_curve_scan_generator.sv]
`default_nettype none

// Hilbert-order pixel address generator. Each request returns one response: on
// restart (req_tdata bit 0 set) the image size is latched from the csr registers and
// the first pixel comes back, otherwise the next pixel of the running scan. The last
// in-bounds pixel is marked with rsp_tlast; once the scan has ended, or before any
// scan, responses carry rsp_tuser set and zero coordinates. A size write takes effect
// at the next restart. The walk covers a 2^order square, order = ceil(log2(max(w,h)))
// saturating at MAX_ORDER, and points outside the image are skipped. A microcoded
// sequencer drives a walk unit that performs one frame-stack action (push, pop or
// move) per cycle. Besides its sequencing steps, each advance walks action by action
// up to the next in-bounds point: every visited point costs one action, and pushes
// and pops add about two thirds more per point on a square power-of-two image; every
// skipped point adds its own actions. A restart also walks down to the first
// in-bounds point. The next request is taken while a response still waits on
// rsp_tready; its response then holds at the send step until the previous one is taken.
module hilbert_curve_scan_generator #(
   parameter int MAX_ORDER = 10
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [hcs_pkg::REQ_DATA_W-1:0]  req_tdata,   // [0] restart
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [hcs_pkg::RSP_DATA_W-1:0]       rsp_tdata,   // [9:0] x_coord, [19:10] y_coord
   output logic                                 rsp_tlast,   // last_pixel
   output logic                                 rsp_tuser,   // [0] scan_done
   input  wire logic                            csr_we,
   input  wire logic [hcs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [hcs_pkg::SIZE_W-1:0]      csr_wdata
);
   import hcs_pkg::*;

   op_type     op;
   status_type status;

   hcs_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .op     (op)
   );

   hcs_datapath #(
      .MAX_ORDER (MAX_ORDER)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .status     (status),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

endmodule

`default_nettype wire

[bench/hilbert_curve_scan_generator_tb.sv]
module hilbert_curve_scan_generator_tb;
   import hcs_pkg::*;

   localparam int STACK_DEPTH   = 10;
   localparam int SQUARE_SIDE   = 1 << STACK_DEPTH;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int RANDOM_ITEMS  = 400;
   localparam int SETTLE_CYCLES = 40;
   localparam int MAX_RUN       = 48;

   typedef enum int {
      PACE_FULL,
      PACE_SLOW_SENDER,
      PACE_SLOW_RECEIVER,
      PACE_BOTH
   } pace_type;

   typedef struct packed {
      logic               scan_done;
      logic               last_pixel;
      logic [COORD_W-1:0] y_coord;
      logic [COORD_W-1:0] x_coord;
   } pixel_type;

   // tracks the walk alongside the block and holds the pixels still owed
   class pixel_scoreboard;
      logic [SIZE_W-1:0]        img_w, img_h;
      logic [SIZE_W-1:0]        lat_w, lat_h;
      logic [15:0]              walk_x, walk_y;
      logic [15:0]              ahead_x, ahead_y;
      logic [5*STACK_DEPTH-1:0] frames;
      int                       level, order;
      bit                       walk_end, finished;
      pixel_type                pending[$];
      int                       errors, responses, restarts, done_answers, last_answers;

      function new();
         img_w        = SIZE_RESET;
         img_h        = SIZE_RESET;
         lat_w        = '0;
         lat_h        = '0;
         walk_x       = '0;
         walk_y       = '0;
         ahead_x      = '0;
         ahead_y      = '0;
         frames       = '0;
         level        = 0;
         order        = 0;
         walk_end     = 1'b0;
         finished     = 1'b1;
         errors       = 0;
         responses    = 0;
         restarts     = 0;
         done_answers = 0;
         last_answers = 0;
      endfunction

      function void set_size(logic [CSR_IDX_W-1:0] idx, logic [SIZE_W-1:0] value);
         if (idx == CSR_IMAGE_WIDTH) img_w = value;
         else if (idx == CSR_IMAGE_HEIGHT) img_h = value;
      endfunction

      // move made at the k-th move of a frame
      function heading_type move_dir(heading_type h, logic [1:0] k);
         logic [5:0] row;
         case (h)
            HD_UP:   row = {HD_UP, HD_RIGHT, HD_DOWN};
            HD_LEFT: row = {HD_LEFT, HD_DOWN, HD_RIGHT};
            HD_DOWN: row = {HD_DOWN, HD_LEFT, HD_UP};
            default: row = {HD_RIGHT, HD_UP, HD_LEFT};
         endcase
         return row[2*k +: 2];
      endfunction

      // heading of the sub-walk entered at a given quarter; middle two share one
      function heading_type sub_dir(heading_type h, logic [1:0] quarter);
         logic [5:0] row;
         int         idx;
         case (h)
            HD_UP:   row = {HD_RIGHT, HD_UP, HD_LEFT};
            HD_LEFT: row = {HD_DOWN, HD_LEFT, HD_UP};
            HD_DOWN: row = {HD_LEFT, HD_DOWN, HD_RIGHT};
            default: row = {HD_UP, HD_RIGHT, HD_DOWN};
         endcase
         idx = (quarter == 2'd0) ? 0 : ((quarter == 2'd3) ? 2 : 1);
         return row[2*idx +: 2];
      endfunction

      function void push_frame(heading_type h);
         logic [5*STACK_DEPTH-1:0] stack;
         frame_type                f;
         if (level < STACK_DEPTH) begin
            f.phase   = '0;
            f.heading = h;
            stack = frames;
            stack[5*level +: 5] = f;
            frames = stack;
            level = level + 1;
         end
      endfunction

      // pops finished frames and expands inner ones until a move turns up
      function bit next_move(output heading_type dir);
         logic [5*STACK_DEPTH-1:0] stack;
         frame_type                f;
         int                       top, depth_left;
         bit                       moved;
         moved = 1'b0;
         dir   = HD_UP;
         while (level > 0 && !moved) begin
            top        = level - 1;
            stack      = frames;
            f          = stack[5*top +: 5];
            depth_left = order - top;
            if ((depth_left <= 1 && f.phase >= LEAF_LAST_PHASE) ||
                (depth_left > 1 && f.phase >= NODE_LAST_PHASE)) begin
               level = level - 1;
            end else begin
               stack[5*top +: 5] = {f.phase + 3'd1, f.heading};
               frames = stack;
               if (depth_left <= 1) begin
                  dir   = move_dir(f.heading, f.phase[1:0]);
                  moved = 1'b1;
               end else if (!f.phase[0]) begin
                  push_frame(sub_dir(f.heading, f.phase[2:1]));
               end else begin
                  dir   = move_dir(f.heading, f.phase[2:1]);
                  moved = 1'b1;
               end
            end
         end
         return moved;
      endfunction

      // walks on to the next in-bounds point, visit first then step
      function bit fetch_next();
         heading_type dir;
         logic [15:0] px, py;
         bit          found;
         found = 1'b0;
         while (!walk_end && !found) begin
            px = walk_x;
            py = walk_y;
            if (!next_move(dir)) begin
               walk_end = 1'b1;
            end else begin
               case (dir)
                  HD_LEFT:  walk_x = walk_x - 16'd1;
                  HD_RIGHT: walk_x = walk_x + 16'd1;
                  HD_UP:    walk_y = walk_y - 16'd1;
                  default:  walk_y = walk_y + 16'd1;
               endcase
            end
            if (px < lat_w && py < lat_h) begin
               ahead_x = px;
               ahead_y = py;
               found   = 1'b1;
            end
         end
         return found;
      endfunction

      function void start_scan();
         logic [SIZE_W-1:0] span;
         lat_w = img_w;
         lat_h = img_h;
         span  = (lat_w > lat_h) ? lat_w : lat_h;
         order = 0;
         while (order < STACK_DEPTH && (1 << order) < span) order = order + 1;
         walk_x   = '0;
         walk_y   = '0;
         walk_end = 1'b0;
         level    = 0;
         if (order > 0) push_frame(HD_UP);
         finished = !fetch_next();
      endfunction

      function void note_request(bit restart);
         pixel_type p;
         if (restart) begin
            start_scan();
            restarts = restarts + 1;
         end
         p = '0;
         if (finished) begin
            p.scan_done = 1'b1;
         end else begin
            p.x_coord    = ahead_x[COORD_W-1:0];
            p.y_coord    = ahead_y[COORD_W-1:0];
            p.last_pixel = !fetch_next();
            if (p.last_pixel) finished = 1'b1;
         end
         pending.push_back(p);
      endfunction

      function void check_pixel(pixel_type got);
         pixel_type want;
         responses = responses + 1;
         if (got.scan_done) done_answers = done_answers + 1;
         if (got.last_pixel) last_answers = last_answers + 1;
         if (pending.size() == 0) begin
            $error("response with no request outstanding: x %0d y %0d last %0b done %0b",
                   got.x_coord, got.y_coord, got.last_pixel, got.scan_done);
            errors = errors + 1;
            return;
         end
         want = pending.pop_front();
         if (got.x_coord !== want.x_coord) begin
            $error("x_coord: expected %0d, got %0d", want.x_coord, got.x_coord);
            errors = errors + 1;
         end
         if (got.y_coord !== want.y_coord) begin
            $error("y_coord: expected %0d, got %0d", want.y_coord, got.y_coord);
            errors = errors + 1;
         end
         if (got.last_pixel !== want.last_pixel) begin
            $error("last_pixel: expected %0b, got %0b", want.last_pixel, got.last_pixel);
            errors = errors + 1;
         end
         if (got.scan_done !== want.scan_done) begin
            $error("scan_done: expected %0b, got %0b", want.scan_done, got.scan_done);
            errors = errors + 1;
         end
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = CSR_IMAGE_WIDTH;
   logic [SIZE_W-1:0]     csr_wdata  = '0;

   pixel_scoreboard tracker;
   int idle_pct     = 0;
   int stall_pct    = 0;
   int random_items = 0;
   int size_writes  = 0;
   int phase_count  = 0;

   hilbert_curve_scan_generator #(
      .MAX_ORDER (STACK_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            tracker.check_pixel({rsp_tuser, rsp_tlast, rsp_tdata[2*COORD_W-1:0]});
         if (req_tvalid && req_tready)
            tracker.note_request(req_tdata[0]);
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $error("no progress after %0d cycles", CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic set_pace(input pace_type pace);
      case (pace)
         PACE_FULL: begin
            idle_pct  = 0;
            stall_pct = 0;
         end
         PACE_SLOW_SENDER: begin
            idle_pct  = 82;
            stall_pct = 0;
         end
         PACE_SLOW_RECEIVER: begin
            idle_pct  = 0;
            stall_pct = 82;
         end
         default: begin
            idle_pct  = 12;
            stall_pct = 12;
         end
      endcase
   endtask

   task automatic send_request(input bit restart);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-1){1'b0}}, restart};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (tracker.pending.size() != 0) @(negedge clock);
   endtask

   // sizes only matter at the next restart, but the block may still be fetching ahead
   task automatic write_sizes(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= w;
      tracker.set_size(CSR_IMAGE_WIDTH, w);
      @(negedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= h;
      tracker.set_size(CSR_IMAGE_HEIGHT, h);
      @(negedge clock);
      csr_we <= 1'b0;
      size_writes = size_writes + 1;
   endtask

   // small sides keep the skipped part of the square cheap to walk
   function automatic int pick_small();
      int r;
      r = $urandom_range(99);
      if (r < 4) return 0;
      if (r < 10) return 1;
      if (r < 85) return $urandom_range(12, 2);
      return $urandom_range(40, 13);
   endfunction

   // large sides: both at least 8 so a short run never leaves the corner block
   function automatic int pick_large();
      int r;
      r = $urandom_range(99);
      if (r < 30) return SQUARE_SIDE;
      if (r < 45) return (1 << SIZE_W) - 1;
      return $urandom_range((1 << SIZE_W) - 1, 8);
   endfunction

   task automatic random_phase(input pace_type pace, input int budget);
      int w, h, pixels, run, advances, sent;
      if ($urandom_range(99) < 15) begin
         w = pick_large();
         h = pick_large();
      end else begin
         w = pick_small();
         h = pick_small();
      end
      pixels = (w == 0 || h == 0) ? 0 :
               ((w > SQUARE_SIDE) ? SQUARE_SIDE : w) * ((h > SQUARE_SIDE) ? SQUARE_SIDE : h);
      write_sizes(SIZE_W'(w), SIZE_W'(h));
      set_pace(pace);
      sent = 0;
      while (sent < budget) begin
         run = (pixels <= MAX_RUN) ? pixels : $urandom_range(MAX_RUN, 8);
         // now and then a scan is cut short by the next restart
         if ($urandom_range(99) < 8) run = $urandom_range(run);
         advances = (run > 0) ? run - 1 : 0;
         if (run == pixels) advances = advances + $urandom_range(2);
         send_request(1'b1);
         sent = sent + 1;
         repeat (advances) begin
            if ($urandom_range(99) < 2) wait_drained();
            send_request($urandom_range(99) < 2);
            sent = sent + 1;
         end
      end
      random_items = random_items + sent;
   endtask

   initial begin
      tracker = new();
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // advance before any scan, then a scan at the reset size
      send_request(1'b0);
      send_request(1'b1);
      send_request(1'b0);
      send_request(1'b0);

      // single pixel: last flagged at once, then done
      write_sizes(1, 1);
      send_request(1'b1);
      send_request(1'b0);
      send_request(1'b0);

      // empty image answers done straight away
      write_sizes(0, 5);
      send_request(1'b1);
      send_request(1'b0);

      write_sizes(2, 2);
      repeat (5) send_request(1'b0 | (tracker.restarts == 3));

      // order saturates, nothing outside the largest square
      write_sizes(SIZE_W'((1 << SIZE_W) - 1), SIZE_W'(1500));
      send_request(1'b1);
      send_request(1'b0);
      send_request(1'b0);

      // a size write mid-scan only counts from the next restart
      write_sizes(3, 5);
      send_request(1'b1);
      send_request(1'b0);
      send_request(1'b0);
      write_sizes(7, 2);
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b1);
      send_request(1'b0);

      while (random_items < RANDOM_ITEMS) begin
         random_phase(pace_type'(phase_count % 4), $urandom_range(70, 25));
         phase_count = phase_count + 1;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (tracker.pending.size() != 0) begin
         $error("%0d responses never arrived", tracker.pending.size());
         tracker.errors = tracker.errors + 1;
      end

      $display("run covered %0d scan starts over %0d size settings and %0d random phases",
               tracker.restarts, size_writes, phase_count);
      $display("responses checked: %0d, of which %0d marked last and %0d answered done",
               tracker.responses, tracker.last_answers, tracker.done_answers);
      if (tracker.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
